>>> rtl/core/dins_pkg.sv
package dins_pkg;

    localparam int PIX_W       = 4;
    localparam int MAX_COLS    = 32;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int MAX_ROWS    = 1024;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ROWS_REG_W  = 11;
    localparam int COLS_REG_W  = 6;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int RAW_AW      = COL_W + 1;
    localparam int RAW_DEPTH   = 2 * MAX_COLS;
    localparam int SUM_W       = 7;
    localparam int MAG_W       = 6;
    localparam int CNT_W       = 3;
    localparam int DIV3_MUL    = 43;
    localparam int DIV3_SHIFT  = 7;
    localparam int PROD_W      = MAG_W + DIV3_SHIFT;

    localparam logic [ROWS_REG_W-1:0] ROWS_RST = ROWS_REG_W'(6);
    localparam logic [COLS_REG_W-1:0] COLS_RST = COLS_REG_W'(8);

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 1'b1;

    typedef struct packed {
        logic              clr;
        logic              acc;
        logic [PIX_W-1:0]  v;
        logic [PIX_W-1:0]  nb;
    } t_alu_cmd;

    typedef struct packed {
        logic              raw_we;
        logic [RAW_AW-1:0] raw_waddr;
        logic [PIX_W-1:0]  raw_wdata;
        logic [RAW_AW-1:0] raw_raddr;
        logic              sm_we;
        logic [COL_W-1:0]  sm_waddr;
        logic [PIX_W-1:0]  sm_wdata;
        logic [COL_W-1:0]  sm_raddr;
    } t_lbuf_ctl;

    function automatic logic [MAG_W-1:0] dins_div_cnt(input logic [MAG_W-1:0] mag,
                                                       input logic [CNT_W-1:0] cnt);
        logic [PROD_W-1:0] prod;
        logic [MAG_W-1:0]  q;
        prod = PROD_W'(mag) * PROD_W'(DIV3_MUL);
        case (cnt)
            CNT_W'(2): q = mag >> 1;
            CNT_W'(3): q = prod[DIV3_SHIFT +: MAG_W];
            CNT_W'(4): q = mag >> 2;
            default:   q = mag;
        endcase
        return q;
    endfunction

endpackage

>>> rtl/core/dins_pix_if.sv
interface dins_pix_if import dins_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

>>> rtl/core/dins_res_if.sv
interface dins_res_if import dins_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] value;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] col_index;
    logic             last;

    modport source (output valid, output value, output row_index, output col_index,
                    output last, input ready);
    modport sink   (input valid, input value, input row_index, input col_index,
                    input last, output ready);
endinterface

>>> rtl/core/dins_lbuf.sv
module dins_lbuf import dins_pkg::*; (
    input  logic             i_clk,
    input  t_lbuf_ctl        i_ctl,
    output logic [PIX_W-1:0] o_raw_q,
    output logic [PIX_W-1:0] o_sm_q
);

    logic [PIX_W-1:0] r_raw_mem [RAW_DEPTH];
    logic [PIX_W-1:0] r_sm_mem  [MAX_COLS];
    logic [PIX_W-1:0] r_raw_q;
    logic [PIX_W-1:0] r_sm_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.raw_we) begin
            r_raw_mem[i_ctl.raw_waddr] <= i_ctl.raw_wdata;
        end
        r_raw_q <= r_raw_mem[i_ctl.raw_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sm_we) begin
            r_sm_mem[i_ctl.sm_waddr] <= i_ctl.sm_wdata;
        end
        r_sm_q <= r_sm_mem[i_ctl.sm_raddr];
    end

    assign o_raw_q = r_raw_q;
    assign o_sm_q  = r_sm_q;

endmodule

>>> rtl/core/dins_alu.sv
module dins_alu import dins_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_alu_cmd         i_cmd,
    output logic [PIX_W-1:0] o_res
);

    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [MAG_W-1:0]        r_abs, n_abs;
    logic [CNT_W-1:0]        r_cnt, n_cnt;

    logic signed [PIX_W:0]   w_diff;
    logic [PIX_W-1:0]        w_adiff;
    logic [SUM_W-1:0]        w_mag;
    logic [MAG_W-1:0]        w_quot;
    logic                    w_apply;

    assign w_diff  = $signed({1'b0, i_cmd.v}) - $signed({1'b0, i_cmd.nb});
    assign w_adiff = w_diff[PIX_W] ? PIX_W'(-w_diff) : PIX_W'(w_diff);

    always_comb begin
        n_sum = r_sum;
        n_abs = r_abs;
        n_cnt = r_cnt;
        if (i_cmd.clr) begin
            n_sum = '0;
            n_abs = '0;
            n_cnt = '0;
        end else if (i_cmd.acc) begin
            n_sum = r_sum + SUM_W'(w_diff);
            n_abs = r_abs + MAG_W'(w_adiff);
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_abs <= '0;
            r_cnt <= '0;
        end else begin
            r_sum <= n_sum;
            r_abs <= n_abs;
            r_cnt <= n_cnt;
        end
    end

    assign w_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_quot  = dins_div_cnt(w_mag[MAG_W-1:0], r_cnt);
    assign w_apply = (r_cnt != '0) && (r_abs > MAG_W'(r_cnt));

    always_comb begin
        o_res = i_cmd.v;
        if (w_apply) begin
            if (r_sum[SUM_W-1]) begin
                o_res = i_cmd.v + w_quot[PIX_W-1:0];
            end else begin
                o_res = i_cmd.v - w_quot[PIX_W-1:0];
            end
        end
    end

endmodule

>>> rtl/core/dins_seq.sv
module dins_seq import dins_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    dins_pix_if.sink              i_pix,
    dins_res_if.source            o_res,
    input  logic [PIX_W-1:0]      i_raw_q,
    input  logic [PIX_W-1:0]      i_sm_q,
    input  logic [PIX_W-1:0]      i_alu_res,
    output t_lbuf_ctl             o_lbuf,
    output t_alu_cmd              o_alu
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ISSUE = 9'b000000010,
        S_LOAD  = 9'b000000100,
        S_LEFT  = 9'b000001000,
        S_RIGHT = 9'b000010000,
        S_UP    = 9'b000100000,
        S_DOWN  = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_END   = 9'b100000000
    } t_state;

    t_state                r_state, n_state;
    logic [ROWS_REG_W-1:0] r_rows, n_rows;
    logic [COLS_REG_W-1:0] r_cols, n_cols;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [COL_W-1:0]      r_col, n_col;
    logic                  r_sel, n_sel;
    logic                  r_burst, n_burst;
    logic [PIX_W-1:0]      r_left, n_left;
    logic                  r_out_valid, n_out_valid;

    logic [PIX_W-1:0]      r_pix, n_pix;
    logic [PIX_W-1:0]      r_v, n_v;
    logic [PIX_W-1:0]      r_up, n_up;
    logic [PIX_W-1:0]      r_right, n_right;
    logic [PIX_W-1:0]      r_out_value, n_out_value;
    logic [ROW_W-1:0]      r_out_row, n_out_row;
    logic [COL_W-1:0]      r_out_col, n_out_col;
    logic                  r_out_last, n_out_last;

    logic [ROWS_REG_W-1:0] w_rows;
    logic [COLS_REG_W-1:0] w_cols;
    logic                  w_col_last;
    logic                  w_row_last;
    logic                  w_bank;
    logic                  w_in_ready;

    always_comb begin
        if (r_rows == '0) begin
            w_rows = ROWS_REG_W'(1);
        end else if (r_rows > ROWS_REG_W'(MAX_ROWS)) begin
            w_rows = ROWS_REG_W'(MAX_ROWS);
        end else begin
            w_rows = r_rows;
        end
        if (r_cols == '0) begin
            w_cols = COLS_REG_W'(1);
        end else if (r_cols > COLS_REG_W'(MAX_COLS)) begin
            w_cols = COLS_REG_W'(MAX_COLS);
        end else begin
            w_cols = r_cols;
        end
    end

    assign w_col_last = (COLS_REG_W'(r_col) + COLS_REG_W'(1)) >= w_cols;
    assign w_row_last = (ROWS_REG_W'(r_row) + ROWS_REG_W'(1)) >= w_rows;
    assign w_bank     = r_burst ? r_sel : ~r_sel;
    assign w_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_rows      = r_rows;
        n_cols      = r_cols;
        n_row       = r_row;
        n_col       = r_col;
        n_sel       = r_sel;
        n_burst     = r_burst;
        n_left      = r_left;
        n_pix       = r_pix;
        n_v         = r_v;
        n_up        = r_up;
        n_right     = r_right;
        n_out_value = r_out_value;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !o_res.ready;

        o_lbuf           = '0;
        o_lbuf.raw_waddr = {r_sel, r_col};
        o_lbuf.raw_wdata = i_pix.pixel;
        o_lbuf.raw_raddr = {w_bank, r_col};
        o_lbuf.sm_waddr  = r_col;
        o_lbuf.sm_wdata  = i_alu_res;
        o_lbuf.sm_raddr  = r_col;

        o_alu     = '0;
        o_alu.v   = r_v;
        o_alu.nb  = r_left;

        unique case (r_state)
            S_IDLE: begin
                if (i_pix.valid) begin
                    n_pix         = i_pix.pixel;
                    o_lbuf.raw_we = 1'b1;
                    n_state       = (r_row != '0) ? S_ISSUE : S_END;
                end
            end
            S_ISSUE: begin
                o_alu.clr = 1'b1;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                n_v              = i_raw_q;
                n_up             = i_sm_q;
                o_lbuf.raw_raddr = {w_bank, r_col + COL_W'(1)};
                n_state          = S_LEFT;
            end
            S_LEFT: begin
                n_right   = i_raw_q;
                o_alu.acc = (r_col != '0);
                o_alu.nb  = r_left;
                n_state   = S_RIGHT;
            end
            S_RIGHT: begin
                o_alu.acc = !w_col_last;
                o_alu.nb  = r_right;
                n_state   = S_UP;
            end
            S_UP: begin
                o_alu.acc = r_burst ? (r_row != '0) : (r_row > ROW_W'(1));
                o_alu.nb  = r_up;
                n_state   = S_DOWN;
            end
            S_DOWN: begin
                o_alu.acc = !r_burst;
                o_alu.nb  = r_pix;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = i_alu_res;
                    n_out_row    = r_burst ? r_row : r_row - ROW_W'(1);
                    n_out_col    = r_col;
                    n_out_last   = r_burst && w_col_last;
                    o_lbuf.sm_we = 1'b1;
                    n_left       = i_alu_res;
                    n_state      = S_END;
                end
            end
            S_END: begin
                if (r_burst) begin
                    if (w_col_last) begin
                        n_burst = 1'b0;
                        n_row   = '0;
                        n_col   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_col   = r_col + COL_W'(1);
                        n_state = S_ISSUE;
                    end
                end else if (w_col_last) begin
                    n_col = '0;
                    if (w_row_last) begin
                        n_burst = 1'b1;
                        n_state = S_ISSUE;
                    end else begin
                        n_row   = r_row + ROW_W'(1);
                        n_sel   = ~r_sel;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_col   = r_col + COL_W'(1);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_ROWS: n_rows = i_cfg_data[ROWS_REG_W-1:0];
                CFG_IDX_COLS: n_cols = i_cfg_data[COLS_REG_W-1:0];
                default: ;
            endcase
            n_row = '0;
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rows      <= ROWS_RST;
            r_cols      <= COLS_RST;
            r_row       <= '0;
            r_col       <= '0;
            r_sel       <= 1'b0;
            r_burst     <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rows      <= n_rows;
            r_cols      <= n_cols;
            r_row       <= n_row;
            r_col       <= n_col;
            r_sel       <= n_sel;
            r_burst     <= n_burst;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix       <= n_pix;
        r_v         <= n_v;
        r_up        <= n_up;
        r_right     <= n_right;
        r_out_value <= n_out_value;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_last  <= n_out_last;
    end

    assign i_pix.ready     = w_in_ready;
    assign o_res.valid     = r_out_valid;
    assign o_res.value     = r_out_value;
    assign o_res.row_index = r_out_row;
    assign o_res.col_index = r_out_col;
    assign o_res.last      = r_out_last;

endmodule

>>> rtl/core/digit_image_neighbor_smoothing.sv
// Four-neighbor smoothing of a digit image streamed in row-major order.
// i_pix carries one raw pixel per request; o_res carries one smoothed pixel
// per request with its row, column and a last flag on the final pixel.
// i_cfg_we/i_cfg_idx/i_cfg_data write the row count (index 0) and column
// count (index 1); any write restarts the image. Write only while idle.
// Pixels of the first row are only stored. Every later pixel releases the
// result of the pixel above it through the issue, load, left, right, up,
// down, output and end states; no new pixel is taken until idle again.
// The final pixel of the image also releases the whole last row.
// The rate is set by the shared accumulate unit, which takes one neighbor
// difference per cycle, and by the single read port of each line buffer.
// Reset: 6 rows by 8 columns, counters at the start of an image.
// A finished result waits in the output register; while it is stalled the
// sequencer holds before writing the next one and i_pix.ready stays low.
module digit_image_neighbor_smoothing import dins_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    dins_pix_if.sink             i_pix,
    dins_res_if.source           o_res
);

    t_lbuf_ctl        w_lbuf;
    t_alu_cmd         w_alu;
    logic [PIX_W-1:0] w_raw_q;
    logic [PIX_W-1:0] w_sm_q;
    logic [PIX_W-1:0] w_alu_res;

    dins_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .o_res      (o_res),
        .i_raw_q    (w_raw_q),
        .i_sm_q     (w_sm_q),
        .i_alu_res  (w_alu_res),
        .o_lbuf     (w_lbuf),
        .o_alu      (w_alu)
    );

    dins_lbuf u_lbuf (
        .i_clk   (i_clk),
        .i_ctl   (w_lbuf),
        .o_raw_q (w_raw_q),
        .o_sm_q  (w_sm_q)
    );

    dins_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_alu),
        .o_res   (w_alu_res)
    );

endmodule

>>> tb/tb.sv
module tb;
    import dins_pkg::*;

    class smoothing_scoreboard;
        typedef struct packed {
            logic [PIX_W-1:0] value;
            logic [ROW_W-1:0] row_index;
            logic [COL_W-1:0] col_index;
            logic             last;
        } t_smoothed_pixel;

        logic [ROWS_REG_W-1:0] rows_reg;
        logic [COLS_REG_W-1:0] cols_reg;
        logic [PIX_W-1:0]      cur_raw[MAX_COLS];
        logic [PIX_W-1:0]      prev_raw[MAX_COLS];
        logic [PIX_W-1:0]      sm_row[MAX_COLS];
        logic [PIX_W-1:0]      left_sm;
        int                    row_cnt;
        int                    col_cnt;
        t_smoothed_pixel       expected_pixels[$];
        int                    mismatches;

        function new();
            rows_reg = ROWS_RST;
            cols_reg = COLS_RST;
            foreach (cur_raw[i]) begin
                cur_raw[i] = '0;
                prev_raw[i] = '0;
                sm_row[i] = '0;
            end
            left_sm = '0;
            row_cnt = 0;
            col_cnt = 0;
            mismatches = 0;
        endfunction

        function int rows_now();
            if (rows_reg == 0) return 1;
            if (rows_reg > MAX_ROWS) return MAX_ROWS;
            return rows_reg;
        endfunction

        function int cols_now();
            if (cols_reg == 0) return 1;
            if (cols_reg > MAX_COLS) return MAX_COLS;
            return cols_reg;
        endfunction

        function int image_area();
            return rows_now() * cols_now();
        endfunction

        function void write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_IDX_ROWS) rows_reg = data[ROWS_REG_W-1:0];
            else cols_reg = data[COLS_REG_W-1:0];
            row_cnt = 0;
            col_cnt = 0;
        endfunction

        function logic [PIX_W-1:0] smooth_pixel(int center, bit has_l, int nb_l, bit has_r,
                                                 int nb_r, bit has_u, int nb_u, bit has_d,
                                                 int nb_d);
            int sum, mag, cnt, d, i;
            bit has[4];
            int nb[4];
            sum = 0;
            mag = 0;
            cnt = 0;
            has = '{has_l, has_r, has_u, has_d};
            nb = '{nb_l, nb_r, nb_u, nb_d};
            for (i = 0; i < 4; i++) begin
                if (has[i]) begin
                    d = center - nb[i];
                    sum += d;
                    mag += (d < 0) ? -d : d;
                    cnt++;
                end
            end
            if (cnt > 0 && mag > cnt) center -= sum / cnt;
            return center[PIX_W-1:0];
        endfunction

        function void expect_pixel(logic [PIX_W-1:0] v, int r, int c, bit last);
            t_smoothed_pixel p;
            p.value = v;
            p.row_index = ROW_W'(r);
            p.col_index = COL_W'(c);
            p.last = last;
            expected_pixels.push_back(p);
        endfunction

        function void take_pixel(logic [PIX_W-1:0] pix);
            int rows, cols, r, c, k;
            bit hr;
            logic [PIX_W-1:0] v, lsm;
            rows = rows_now();
            cols = cols_now();
            if (row_cnt >= rows || col_cnt >= cols) begin
                row_cnt = 0;
                col_cnt = 0;
            end
            r = row_cnt;
            c = col_cnt;
            cur_raw[c] = pix;
            if (r > 0) begin
                hr = (c + 1 < cols);
                v = smooth_pixel(prev_raw[c], c > 0, left_sm, hr, hr ? prev_raw[c + 1] : 0,
                                 r > 1, sm_row[c], 1'b1, pix);
                sm_row[c] = v;
                left_sm = v;
                expect_pixel(v, r - 1, c, 1'b0);
            end
            if (c + 1 >= cols) begin
                if (r + 1 >= rows) begin
                    lsm = '0;
                    for (k = 0; k < cols; k++) begin
                        hr = (k + 1 < cols);
                        v = smooth_pixel(cur_raw[k], k > 0, lsm, hr,
                                         hr ? cur_raw[k + 1] : 0, r > 0, sm_row[k], 1'b0, 0);
                        sm_row[k] = v;
                        lsm = v;
                        expect_pixel(v, r, k, k + 1 == cols);
                    end
                    left_sm = lsm;
                    row_cnt = 0;
                end else begin
                    prev_raw = cur_raw;
                    row_cnt = r + 1;
                end
                col_cnt = 0;
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void check_pixel(logic [PIX_W-1:0] value, logic [ROW_W-1:0] row_index,
                                  logic [COL_W-1:0] col_index, logic last);
            t_smoothed_pixel want;
            if (expected_pixels.size() == 0) begin
                $error("unexpected result: value %0d row %0d col %0d last %0d",
                       value, row_index, col_index, last);
                mismatches++;
                return;
            end
            want = expected_pixels.pop_front();
            if (value !== want.value) begin
                $error("value: expected %0d, got %0d", want.value, value);
                mismatches++;
            end
            if (row_index !== want.row_index) begin
                $error("row_index: expected %0d, got %0d", want.row_index, row_index);
                mismatches++;
            end
            if (col_index !== want.col_index) begin
                $error("col_index: expected %0d, got %0d", want.col_index, col_index);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    int                   src_gap_pct = 0;
    int                   sink_stall_pct = 0;

    smoothing_scoreboard sb = new();

    dins_pix_if pix_if ();
    dins_res_if res_if ();

    digit_image_neighbor_smoothing dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready)
                sb.check_pixel(res_if.value, res_if.row_index, res_if.col_index, res_if.last);
            if (pix_if.valid && pix_if.ready) sb.take_pixel(pix_if.pixel);
            if (i_cfg_we) sb.write_size(i_cfg_idx, i_cfg_data);
        end
    end

    initial begin : sink_ctl
        int hold;
        hold = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) hold--;
            else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct)
                hold = $urandom_range(1, 6);
            res_if.ready <= (hold == 0);
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel(int mode, logic [PIX_W-1:0] bg);
        case (mode)
            0: return PIX_W'($urandom_range(0, 15));
            1: return PIX_W'($urandom_range(0, 9));
            2: return ($urandom_range(0, 5) == 0) ? PIX_W'($urandom_range(0, 15)) : bg;
            default: begin
                case ($urandom_range(0, 2))
                    0: return 4'd0;
                    1: return 4'd9;
                    default: return 4'd15;
                endcase
            end
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= pix;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
    endtask

    task automatic send_seq(input logic [PIX_W-1:0] seq[$]);
        foreach (seq[i]) send_pixel(seq[i]);
    endtask

    task automatic drain_results(input int settle);
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic program_size(input bit wr_rows, input logic [CFG_W-1:0] rows_data,
                                input bit wr_cols, input logic [CFG_W-1:0] cols_data);
        drain_results(16);
        if (wr_rows) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CFG_IDX_ROWS;
            i_cfg_data <= rows_data;
            @(posedge i_clk);
        end
        if (wr_cols) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CFG_IDX_COLS;
            i_cfg_data <= cols_data;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic stream_pixels(input int count, input int mode, input bit allow_pause);
        int pause_at;
        logic [PIX_W-1:0] bg;
        bg = PIX_W'($urandom_range(0, 9));
        pause_at = allow_pause ? $urandom_range(0, count - 1) : -1;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) drain_results(0);
            send_pixel(pick_pixel(mode, bg));
        end
    endtask

    initial begin : stimulus
        int total, rows, cols, area, count, pick;
        int pct_choice[4];
        logic [CFG_W-1:0] cols_data;
        pct_choice = '{0, 10, 25, 50};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_IDX_ROWS;
        i_cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_stall_pct = 20;

        send_seq('{1, 0, 9, 15, 2, 8, 3, 7, 4});
        program_size(1'b1, 1, 1'b1, 1);
        send_seq('{0, 9, 15});
        program_size(1'b1, 0, 1'b1, 0);
        send_seq('{6});
        program_size(1'b1, 2, 1'b1, 3);
        send_seq('{0, 15, 0, 15, 0, 9});
        program_size(1'b1, 3, 1'b1, 2);
        send_seq('{9, 0, 9});
        program_size(1'b1, 2, 1'b0, 0);
        send_seq('{1, 14, 10, 2});

        src_gap_pct = 15;
        program_size(1'b1, 2, 1'b1, 63);
        stream_pixels(64, 1, 1'b1);
        program_size(1'b1, CFG_W'(MAX_ROWS), 1'b1, 1);
        stream_pixels(5, 0, 1'b0);
        program_size(1'b1, 2047, 1'b0, 0);
        stream_pixels(40, 2, 1'b1);

        total = 0;
        while (total < 260) begin
            src_gap_pct = pct_choice[$urandom_range(0, 3)];
            sink_stall_pct = pct_choice[$urandom_range(0, 3)];
            rows = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
            case ($urandom_range(0, 9))
                0: cols = 0;
                1: cols = MAX_COLS;
                2: cols = $urandom_range(MAX_COLS + 1, 63);
                3: cols = $urandom_range(9, MAX_COLS - 1);
                default: cols = $urandom_range(1, 8);
            endcase
            if (cols > 8) rows = $urandom_range(0, 2);
            cols_data = CFG_W'(cols);
            if ($urandom_range(0, 3) == 0)
                cols_data[CFG_W-1:COLS_REG_W] = (CFG_W-COLS_REG_W)'($urandom_range(0, 31));
            pick = $urandom_range(0, 5);
            case (pick)
                0: program_size(1'b1, CFG_W'(rows), 1'b0, 0);
                1: program_size(1'b0, 0, 1'b1, cols_data);
                2: ;
                default: program_size(1'b1, CFG_W'(rows), 1'b1, cols_data);
            endcase
            area = sb.image_area();
            count = area * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, area);
            stream_pixels(count, $urandom_range(0, 3), 1'b1);
            total += count;
        end

        src_gap_pct = 0;
        sink_stall_pct = 0;
        program_size(1'b1, 3, 1'b1, 4);
        stream_pixels(24, 0, 1'b0);

        drain_results(20);
        if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/dins_pkg.sv
rtl/core/dins_pix_if.sv
rtl/core/dins_res_if.sv
rtl/core/dins_lbuf.sv
rtl/core/dins_alu.sv
rtl/core/dins_seq.sv
rtl/core/digit_image_neighbor_smoothing.sv
tb/tb.sv
